>>> hw/rtl/utdb_pkg.sv
// Shared types, constants and microcode for the transfer descriptor builder.
// No dependencies; imported by utdb_seq, utdb_dp and the top level.
package utdb_pkg;

    localparam int POOL_DEPTH = 32;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET = 1'd1;

    localparam logic [9:0]  MAX_PACKET_RST = 10'd8;

    // packet ids
    localparam logic [7:0]  PID_IN    = 8'h69;
    localparam logic [7:0]  PID_OUT   = 8'he1;
    localparam logic [7:0]  PID_SETUP = 8'h2d;

    // error count 3, active
    localparam logic [31:0] CS_BASE       = 32'h1880_0000;
    localparam int          CS_LS_BIT     = 26;
    localparam logic [31:0] LINK_TERM     = 32'h0000_0001;
    localparam logic [4:0]  LINK_DEPTH    = 5'b00100;
    localparam logic [10:0] SETUP_LEN_ENC = 11'd7;
    localparam logic [10:0] ZERO_LEN_ENC  = 11'h7ff;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_SETUP  = 3'd1;
    localparam step_t STEP_DATA   = 3'd2;
    localparam step_t STEP_STATUS = 3'd3;
    localparam step_t STEP_POLL   = 3'd4;
    localparam step_t STEP_ERR    = 3'd5;

    typedef enum logic [2:0] {
        EK_NONE,
        EK_SETUP,
        EK_DATA,
        EK_STATUS,
        EK_POLL,
        EK_ERROR
    } emit_kind_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_POLL,
        C_REM_ZERO
    } cond_t;

    typedef struct packed {
        logic       wait_in;
        emit_kind_t kind;
        cond_t      cond;
        logic       chk_pool;
        step_t      jump;
        step_t      next;
    } ctl_t;

    // sequencer -> datapath
    typedef struct packed {
        logic       load;
        logic       emit;
        emit_kind_t kind;
    } cmd_t;

    // datapath -> sequencer
    typedef struct packed {
        logic rem_zero;
        logic pool_full;
        logic out_ready;
    } stat_t;

    function automatic ctl_t ucode(input step_t step);
        ctl_t c;
        c = '{wait_in: 1'b0, kind: EK_NONE, cond: C_NONE, chk_pool: 1'b0,
              jump: STEP_FETCH, next: STEP_FETCH};
        unique case (step)
            STEP_FETCH:  begin
                c.wait_in = 1'b1;
                c.cond    = C_POLL;
                c.jump    = STEP_POLL;
                c.next    = STEP_SETUP;
            end
            STEP_SETUP:  begin
                c.kind = EK_SETUP;
                c.next = STEP_DATA;
            end
            STEP_DATA:   begin
                c.kind     = EK_DATA;
                c.cond     = C_REM_ZERO;
                c.jump     = STEP_STATUS;
                c.chk_pool = 1'b1;
                c.next     = STEP_DATA;
            end
            STEP_STATUS: c.kind = EK_STATUS;
            STEP_POLL:   c.kind = EK_POLL;
            STEP_ERR:    c.kind = EK_ERROR;
            default:     c.kind = EK_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/utdb_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on utdb_pkg.
module utdb_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_func,
    input  utdb_pkg::stat_t st,
    output logic            in_take,
    output utdb_pkg::cmd_t  cmd
);
    import utdb_pkg::*;

    step_t step_reg;
    step_t step_next;
    ctl_t  ctl;
    logic  cond_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctl = ucode(step_reg);
        unique case (ctl.cond)
            C_NONE:     cond_hit = 1'b0;
            C_POLL:     cond_hit = in_func;
            C_REM_ZERO: cond_hit = st.rem_zero;
            default:    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        in_take   = ctl.wait_in;
        cmd.load  = 1'b0;
        cmd.emit  = 1'b0;
        cmd.kind  = ctl.kind;
        step_next = step_reg;
        priority if (ctl.wait_in)
        begin
            if (in_valid)
            begin
                cmd.load  = 1'b1;
                step_next = cond_hit ? ctl.jump : ctl.next;
            end
        end
        else if (cond_hit)
        begin
            step_next = ctl.jump;
        end
        else if (ctl.chk_pool && st.pool_full)
        begin
            step_next = STEP_ERR;
        end
        else if (st.out_ready)
        begin
            cmd.emit  = 1'b1;
            step_next = ctl.next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_ERR)
        else $error("step counter outside program");

    a_load_only_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> step_reg == STEP_FETCH)
        else $error("load outside fetch step");

    a_err_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_ERR) && !$past(step_reg == STEP_ERR)
        |-> $past(step_reg == STEP_DATA))
        else $error("error step entered from wrong step");

endmodule

>>> hw/rtl/utdb_dp.sv
// Datapath: config registers, request registers, packet splitter, descriptor
// word assembly and output register. Depends on utdb_pkg.
module utdb_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [utdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utdb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  utdb_pkg::cmd_t                  cmd,
    output utdb_pkg::stat_t                 st,
    input  logic                            low_speed,
    input  logic [6:0]                      device_address,
    input  logic [3:0]                      endpoint,
    input  logic [7:0]                      request_type,
    input  logic [15:0]                     transfer_length,
    input  logic [31:0]                     setup_buffer_addr,
    input  logic [31:0]                     data_buffer_addr,
    input  logic                            poll_toggle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [4:0]                      slot_index,
    output logic [31:0]                     link_word,
    output logic [31:0]                     control_word,
    output logic [31:0]                     token_word,
    output logic [31:0]                     buffer_word,
    output logic                            run_last,
    output logic                            too_large
);
    import utdb_pkg::*;

    // config
    logic [26:0] pool_base_reg;
    logic [9:0]  max_packet_reg;

    // request
    logic              ls_reg;
    logic [6:0]        addr_reg;
    logic [3:0]        ep_reg;
    logic              d2h_reg;
    logic [15:0]       rem_reg;
    logic [15:0]       rem_next;
    logic [31:0]       ptr_reg;
    logic [31:0]       ptr_next;
    logic [31:0]       setup_reg;
    logic              ptog_reg;
    logic              tog_reg;
    logic [SLOT_W-1:0] slot_reg;

    // output stage
    logic        out_valid_reg;
    logic [4:0]  slot_out_reg;
    logic [31:0] link_reg;
    logic [31:0] cs_reg;
    logic [31:0] tok_reg;
    logic [31:0] buf_reg;
    logic        last_reg;
    logic        err_reg;

    logic [9:0]        mp;
    logic [9:0]        size;
    logic [10:0]       enc;
    logic [15:0]       poll_len_m1;
    logic [SLOT_W-1:0] slot_inc;
    logic [26:0]       link_hi;
    logic [SLOT_W+4:0] slot_ext;
    logic              ovf_next;
    logic              term;
    logic [31:0]       link_d;
    logic [31:0]       tok_d;
    logic [31:0]       buf_d;
    logic              tog_d;
    logic [3:0]        ep_d;
    logic [7:0]        pid_d;
    logic [4:0]        slot_d;
    logic              last_d;
    logic              err_d;

    function automatic logic [15:0] transfer_len_m1(input logic [15:0] len);
        return len - 16'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            max_packet_reg <= MAX_PACKET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg  <= cfg_data[31:5];
                CFG_MAX_PACKET: max_packet_reg <= cfg_data[9:0];
                default:        ;
            endcase
        end
    end

    // packet splitter
    always_comb
    begin
        mp       = (max_packet_reg == 10'd0) ? 10'd1 : max_packet_reg;
        size     = (rem_reg > {6'd0, mp}) ? mp : rem_reg[9:0];
        rem_next = rem_reg - {6'd0, size};
        ptr_next = ptr_reg + {22'd0, size};
        slot_inc = slot_reg + 1'b1;
        link_hi  = pool_base_reg + 27'(slot_inc);
        slot_ext = {5'd0, slot_reg};
        // a data packet is the last descriptor when the next one would not fit
        ovf_next = (rem_next != 16'd0) && (slot_reg == SLOT_W'(POOL_DEPTH - 2));
        poll_len_m1 = transfer_len_m1(rem_reg);
        st.rem_zero  = (rem_reg == 16'd0);
        st.pool_full = (slot_reg == SLOT_W'(POOL_DEPTH - 1));
        st.out_ready = !out_valid_reg || !out_stall;
    end

    // descriptor word assembly
    always_comb
    begin
        enc    = ZERO_LEN_ENC;
        tog_d  = 1'b0;
        ep_d   = 4'd0;
        pid_d  = PID_SETUP;
        buf_d  = 32'd0;
        term   = 1'b0;
        last_d = 1'b0;
        err_d  = 1'b0;
        unique case (cmd.kind)
            EK_SETUP:  begin
                enc   = SETUP_LEN_ENC;
                buf_d = setup_reg;
            end
            EK_DATA:   begin
                enc   = 11'({1'b0, size} - 11'd1);
                tog_d = ~tog_reg;
                pid_d = d2h_reg ? PID_IN : PID_OUT;
                buf_d = ptr_reg;
                term  = ovf_next;
            end
            EK_STATUS: begin
                tog_d  = 1'b1;
                pid_d  = d2h_reg ? PID_OUT : PID_IN;
                term   = 1'b1;
                last_d = 1'b1;
            end
            EK_POLL:   begin
                enc    = poll_len_m1[10:0];
                tog_d  = ptog_reg;
                ep_d   = ep_reg;
                pid_d  = PID_IN;
                buf_d  = ptr_reg;
                term   = 1'b1;
                last_d = 1'b1;
            end
            EK_ERROR:  begin
                last_d = 1'b1;
                err_d  = 1'b1;
            end
            default:   ;
        endcase
        tok_d  = {enc, 1'b0, tog_d, ep_d, addr_reg, pid_d};
        link_d = term ? LINK_TERM : {link_hi, LINK_DEPTH};
        slot_d = slot_ext[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ls_reg    <= low_speed;
            addr_reg  <= device_address;
            ep_reg    <= endpoint;
            d2h_reg   <= request_type[7];
            rem_reg   <= transfer_length;
            ptr_reg   <= data_buffer_addr;
            setup_reg <= setup_buffer_addr;
            ptog_reg  <= poll_toggle;
            tog_reg   <= 1'b0;
            slot_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            slot_reg <= slot_inc;
            if (cmd.kind == EK_DATA)
            begin
                rem_reg <= rem_next;
                ptr_reg <= ptr_next;
                tog_reg <= ~tog_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            slot_out_reg <= err_d ? 5'd0 : slot_d;
            link_reg     <= err_d ? 32'd0 : link_d;
            cs_reg       <= err_d ? 32'd0 : (CS_BASE | (32'(ls_reg) << CS_LS_BIT));
            tok_reg      <= err_d ? 32'd0 : tok_d;
            buf_reg      <= buf_d;
            last_reg     <= last_d;
            err_reg      <= err_d;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot_index   = slot_out_reg;
    assign link_word    = link_reg;
    assign control_word = cs_reg;
    assign token_word   = tok_reg;
    assign buffer_word  = buf_reg;
    assign run_last     = last_reg;
    assign too_large    = err_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> last_reg && link_reg == 32'd0 && slot_out_reg == 5'd0)
        else $error("error transfer malformed");

    a_last_terminates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg && !err_reg |-> link_reg == LINK_TERM)
        else $error("last descriptor does not terminate");

    a_chain_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg && link_reg != LINK_TERM |-> link_reg[2])
        else $error("chained link without depth bit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !cmd.emit)
        else $error("output register overwritten while stalled");

endmodule

>>> hw/rtl/usb_transfer_descriptor_builder_unit.sv
// Top level of the USB transfer descriptor builder.
// Depends on utdb_pkg, utdb_seq and utdb_dp.
//
// Usage:
//  - Request channel (in_valid/in_stall plus one port per field) takes one
//    request when in_valid is high and in_stall low. in_stall is low only
//    while the sequencer sits in its fetch step.
//  - Result channel (out_valid/out_stall) delivers one descriptor per
//    transfer: slot, link, control/status, token and buffer words, with
//    run_last on the final transfer of a run and too_large on the error
//    transfer that ends a run overflowing the pool.
//  - Config port: cfg_we, cfg_index (0 pool base, 1 max packet), cfg_data.
//    Write only when no run is in progress.
//  Flow: a taken request is loaded into the request registers; the first
//  descriptor is then assembled from them into the output register. The
//  microcode then emits the descriptors of the run in order, while the data
//  step emits nothing when it sees the data stage end. There is a single
//  output register: while the result side stalls a valid descriptor, the
//  sequencer holds. A new request is taken only after the last descriptor
//  of the previous run has been loaded into the output register.
//  Reset puts the sequencer in its fetch step, drops out_valid and sets
//  pool base 0, max packet 8.
module usb_transfer_descriptor_builder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [utdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [utdb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic                            low_speed,
    input  logic [6:0]                      device_address,
    input  logic [3:0]                      endpoint,
    input  logic [7:0]                      request_type,
    input  logic [15:0]                     transfer_length,
    input  logic [31:0]                     setup_buffer_addr,
    input  logic [31:0]                     data_buffer_addr,
    input  logic                            poll_toggle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [4:0]                      slot_index,
    output logic [31:0]                     link_word,
    output logic [31:0]                     control_word,
    output logic [31:0]                     token_word,
    output logic [31:0]                     buffer_word,
    output logic                            run_last,
    output logic                            too_large
);
    import utdb_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  in_take;

    assign in_stall = !in_take;

    utdb_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (func),
        .st       (st),
        .in_take  (in_take),
        .cmd      (cmd)
    );

    utdb_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .st                (st),
        .low_speed         (low_speed),
        .device_address    (device_address),
        .endpoint          (endpoint),
        .request_type      (request_type),
        .transfer_length   (transfer_length),
        .setup_buffer_addr (setup_buffer_addr),
        .data_buffer_addr  (data_buffer_addr),
        .poll_toggle       (poll_toggle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .slot_index        (slot_index),
        .link_word         (link_word),
        .control_word      (control_word),
        .token_word        (token_word),
        .buffer_word       (buffer_word),
        .run_last          (run_last),
        .too_large         (too_large)
    );

endmodule

>>> verif/usb_transfer_descriptor_builder_unit_tb.sv
// Self-checking testbench for usb_transfer_descriptor_builder_unit.
// Predicts every descriptor of each request from its own copy of the config
// and checks the result channel in order. Depends on utdb_pkg and the RTL.
module usb_transfer_descriptor_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utdb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic        func;
        logic        low_speed;
        logic [6:0]  device_address;
        logic [3:0]  endpoint;
        logic [7:0]  request_type;
        logic [15:0] transfer_length;
        logic [31:0] setup_buffer_addr;
        logic [31:0] data_buffer_addr;
        logic        poll_toggle;
    } request_t;

    typedef struct {
        logic [4:0]  slot;
        logic [31:0] link;
        logic [31:0] ctrl;
        logic [31:0] tok;
        logic [31:0] bufw;
        logic        last;
        logic        err;
    } descriptor_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_POOL_BASE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  func = 1'b0;
    logic                  low_speed = 1'b0;
    logic [6:0]            device_address = '0;
    logic [3:0]            endpoint = '0;
    logic [7:0]            request_type = '0;
    logic [15:0]           transfer_length = '0;
    logic [31:0]           setup_buffer_addr = '0;
    logic [31:0]           data_buffer_addr = '0;
    logic                  poll_toggle = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [4:0]            slot_index;
    logic [31:0]           link_word;
    logic [31:0]           control_word;
    logic [31:0]           token_word;
    logic [31:0]           buffer_word;
    logic                  run_last;
    logic                  too_large;

    // config as the block should hold it
    logic [31:0] pool_base_cfg = 32'd0;
    logic [9:0]  max_packet_cfg = MAX_PACKET_RST;

    request_t    pending_q[$];
    descriptor_t desc_q[$];
    request_t    cur_req;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    usb_transfer_descriptor_builder_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .low_speed         (low_speed),
        .device_address    (device_address),
        .endpoint          (endpoint),
        .request_type      (request_type),
        .transfer_length   (transfer_length),
        .setup_buffer_addr (setup_buffer_addr),
        .data_buffer_addr  (data_buffer_addr),
        .poll_toggle       (poll_toggle),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .slot_index        (slot_index),
        .link_word         (link_word),
        .control_word      (control_word),
        .token_word        (token_word),
        .buffer_word       (buffer_word),
        .run_last          (run_last),
        .too_large         (too_large)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("usb_transfer_descriptor_builder_unit_tb: errors");
            $finish;
        end
    end

    // length field holds len-1 in 11 bits, so zero length encodes as all ones
    function automatic logic [31:0] token_of(input logic [15:0] len, input logic tog,
                                             input logic [3:0] ep, input logic [6:0] dev,
                                             input logic [7:0] pid);
        logic [15:0] enc;
        enc = len - 16'd1;
        return {enc[10:0], 1'b0, tog, ep, dev, pid};
    endfunction

    function automatic void predict_descriptors(input request_t r);
        logic [31:0] tok_a [POOL_DEPTH];
        logic [31:0] buf_a [POOL_DEPTH];
        int          n;
        int          i;
        int          mp;
        int          left;
        int          sz;
        logic        ovf;
        logic        tog;
        logic [31:0] off;
        logic [31:0] base;
        logic [31:0] ctrl;
        logic [7:0]  data_pid;
        logic [7:0]  stat_pid;
        descriptor_t d;
        n = 0;
        ovf = 1'b0;
        base = {pool_base_cfg[31:5], 5'b0};
        ctrl = CS_BASE | (32'(r.low_speed) << CS_LS_BIT);
        if (r.func)
        begin
            tok_a[0] = token_of(r.transfer_length, r.poll_toggle, r.endpoint,
                                r.device_address, PID_IN);
            buf_a[0] = r.data_buffer_addr;
            n = 1;
        end
        else
        begin
            mp = (max_packet_cfg == 10'd0) ? 1 : int'(max_packet_cfg);
            data_pid = r.request_type[7] ? PID_IN : PID_OUT;
            stat_pid = r.request_type[7] ? PID_OUT : PID_IN;
            tok_a[0] = token_of(16'd8, 1'b0, 4'd0, r.device_address, PID_SETUP);
            buf_a[0] = r.setup_buffer_addr;
            n = 1;
            left = int'(r.transfer_length);
            off = 32'd0;
            tog = 1'b0;
            while (left > 0 && !ovf)
            begin
                // last slot is reserved for the status stage
                if (n + 1 >= POOL_DEPTH)
                    ovf = 1'b1;
                else
                begin
                    tog = ~tog;
                    sz = (left > mp) ? mp : left;
                    tok_a[n] = token_of(16'(sz), tog, 4'd0, r.device_address, data_pid);
                    buf_a[n] = r.data_buffer_addr + off;
                    n++;
                    off = off + 32'(sz);
                    left = left - sz;
                end
            end
            if (!ovf)
            begin
                tok_a[n] = token_of(16'd0, 1'b1, 4'd0, r.device_address, stat_pid);
                buf_a[n] = 32'd0;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            d.slot = 5'(i);
            d.link = (i + 1 < n) ? ((base + 32'(i + 1) * 32'd32) | 32'(LINK_DEPTH))
                                 : LINK_TERM;
            d.ctrl = ctrl;
            d.tok  = tok_a[i];
            d.bufw = buf_a[i];
            d.last = !ovf && (i + 1 == n);
            d.err  = 1'b0;
            desc_q.push_back(d);
        end
        if (ovf)
        begin
            d = '{slot: '0, link: '0, ctrl: '0, tok: '0, bufw: '0, last: 1'b1, err: 1'b1};
            desc_q.push_back(d);
        end
    endfunction

    function automatic request_t make_request(input logic f, input logic ls,
                                              input logic [6:0] dev, input logic [3:0] ep,
                                              input logic [7:0] rtype, input logic [15:0] len,
                                              input logic [31:0] setup_a,
                                              input logic [31:0] data_a, input logic tog);
        request_t r;
        r.func = f;
        r.low_speed = ls;
        r.device_address = dev;
        r.endpoint = ep;
        r.request_type = rtype;
        r.transfer_length = len;
        r.setup_buffer_addr = setup_a;
        r.data_buffer_addr = data_a;
        r.poll_toggle = tog;
        return r;
    endfunction

    // lengths are short, cluster around the pool boundary for the current packet size, or span the full range
    function automatic request_t random_request();
        request_t r;
        int mp;
        int pick;
        int lo;
        int hi;
        mp = (max_packet_cfg == 10'd0) ? 1 : int'(max_packet_cfg);
        r = make_request($urandom_range(0, 99) < 25, 1'($urandom_range(0, 1)),
                         7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), 16'd0, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            lo = 0;
            hi = 4 * mp;
        end
        else if (pick < 75)
        begin
            lo = 28 * mp;
            hi = 31 * mp;
        end
        else if (pick < 90)
        begin
            lo = 0;
            hi = 65535;
        end
        else
        begin
            lo = 0;
            hi = 30 * mp;
        end
        if (hi > 65535)
            hi = 65535;
        if (lo > hi)
            lo = hi;
        r.transfer_length = 16'($urandom_range(lo, hi));
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_POOL_BASE)
            pool_base_cfg = val;
        else
            max_packet_cfg = val[9:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (!(pending_q.size() == 0 && !in_valid && desc_q.size() == 0))
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_descriptors(cur_req);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_req = pending_q.pop_front();
                    func <= cur_req.func;
                    low_speed <= cur_req.low_speed;
                    device_address <= cur_req.device_address;
                    endpoint <= cur_req.endpoint;
                    request_type <= cur_req.request_type;
                    transfer_length <= cur_req.transfer_length;
                    setup_buffer_addr <= cur_req.setup_buffer_addr;
                    data_buffer_addr <= cur_req.data_buffer_addr;
                    poll_toggle <= cur_req.poll_toggle;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side stall: mode changes now and then, plus long hold-offs
    always @(posedge clk)
    begin : rx_stall
        static rx_mode_t mode = RX_OPEN;
        static int mode_left = 0;
        static int hold_left = 0;
        static int rx_seen = 0;
        static int next_hold = 120;
        static int phase_cnt = 0;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                rx_seen++;
            phase_cnt++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_seen >= next_hold)
            begin
                hold_left = $urandom_range(300, 500);
                next_hold = rx_seen + 900;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                else
                    mode_left--;
                case (mode)
                    RX_OPEN:     out_stall <= 1'b0;
                    RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
                    RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 70);
                    default:     out_stall <= (phase_cnt % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        descriptor_t got;
        descriptor_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.slot = slot_index;
            got.link = link_word;
            got.ctrl = control_word;
            got.tok  = token_word;
            got.bufw = buffer_word;
            got.last = run_last;
            got.err  = too_large;
            if (desc_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("%0t unexpected descriptor slot=%0d link=%h tok=%h err=%b",
                             $realtime, got.slot, got.link, got.tok, got.err);
            end
            else
            begin
                want = desc_q.pop_front();
                if (got.slot !== want.slot || got.link !== want.link ||
                    got.ctrl !== want.ctrl || got.tok !== want.tok ||
                    got.bufw !== want.bufw || got.last !== want.last ||
                    got.err !== want.err)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("%0t descriptor mismatch", $realtime);
                        $display("  exp slot=%0d link=%h ctrl=%h tok=%h buf=%h last=%b err=%b",
                                 want.slot, want.link, want.ctrl, want.tok, want.bufw,
                                 want.last, want.err);
                        $display("  got slot=%0d link=%h ctrl=%h tok=%h buf=%h last=%b err=%b",
                                 got.slot, got.link, got.ctrl, got.tok, got.bufw,
                                 got.last, got.err);
                    end
                end
            end
        end
    end

    initial
    begin
        int p;
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset config: base 0, 8-byte packets
        pending_q.push_back(make_request(1'b1, 1'b0, 7'd0, 4'd0, 8'h00, 16'd0,
                                         32'h0, 32'h0, 1'b0));
        pending_q.push_back(make_request(1'b1, 1'b1, 7'd127, 4'd15, 8'hff, 16'hffff,
                                         32'hffff_ffff, 32'hffff_ffff, 1'b1));
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd1, 4'd0, 8'h80, 16'd0,
                                         32'h1000_0000, 32'h2000_0000, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd2, 4'd3, 8'h00, 16'd0,
                                         32'h0000_0008, 32'h0, 1'b1));
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd3, 4'd0, 8'hff, 16'd1,
                                         32'haaaa_aaaa, 32'h5555_5555, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd64, 4'd0, 8'h7f, 16'd8,
                                         32'h5555_5555, 32'haaaa_aaaa, 1'b0));
        // data buffer wraps past the top of the address space
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd5, 4'd0, 8'h80, 16'd9,
                                         32'h0, 32'hffff_fffc, 1'b0));
        // exactly fills the pool, then one byte over
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd6, 4'd0, 8'h80, 16'd240,
                                         32'h100, 32'h200, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd7, 4'd0, 8'h00, 16'd241,
                                         32'h100, 32'h200, 1'b1));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd127, 4'd15, 8'hff, 16'hffff,
                                         32'hffff_ffff, 32'hffff_ffff, 1'b1));
        wait_idle();

        // top pool base makes link words wrap; largest packet size
        write_reg(CFG_POOL_BASE, 32'hffff_ffe0);
        write_reg(CFG_MAX_PACKET, 32'd1023);
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd9, 4'd0, 8'h80, 16'd30690,
                                         32'h40, 32'h8000_0000, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd10, 4'd0, 8'h00, 16'd30691,
                                         32'h40, 32'h8000_0000, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd11, 4'd0, 8'h81, 16'd1023,
                                         32'h44, 32'hffff_f000, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd12, 4'd0, 8'h01, 16'd1024,
                                         32'h48, 32'hffff_fc00, 1'b0));
        pending_q.push_back(make_request(1'b1, 1'b0, 7'd13, 4'd9, 8'h00, 16'd1024,
                                         32'h0, 32'h1234_0000, 1'b1));
        wait_idle();

        // unaligned base, single-byte packets
        write_reg(CFG_POOL_BASE, 32'h1234_567f);
        write_reg(CFG_MAX_PACKET, 32'd1);
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd20, 4'd0, 8'h80, 16'd30,
                                         32'h10, 32'h20, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b1, 7'd21, 4'd0, 8'h00, 16'd31,
                                         32'h10, 32'h20, 1'b0));
        pending_q.push_back(make_request(1'b0, 1'b0, 7'd22, 4'd0, 8'hc0, 16'd2,
                                         32'h10, 32'h20, 1'b0));
        pending_q.push_back(make_request(1'b1, 1'b1, 7'd23, 4'd1, 8'h00, 16'd1,
                                         32'h0, 32'h30, 1'b0));
        wait_idle();

        for (p = 0; p < 4; p++)
        begin
            write_reg(CFG_POOL_BASE, $urandom);
            case (p)
                0:       write_reg(CFG_MAX_PACKET, 32'd1023);
                1:       write_reg(CFG_MAX_PACKET, 32'($urandom_range(1, 16)));
                2:       write_reg(CFG_MAX_PACKET, 32'($urandom_range(1, 1023)));
                default: write_reg(CFG_MAX_PACKET, 32'd1);
            endcase
            for (k = 0; k < 25; k++)
                pending_q.push_back(random_request());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (desc_q.size() != 0)
        begin
            fail_cnt++;
            $display("%0d descriptors never arrived", desc_q.size());
        end
        if (fail_cnt == 0)
            $display("usb_transfer_descriptor_builder_unit_tb: clean");
        else
            $display("usb_transfer_descriptor_builder_unit_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/utdb_pkg.sv
hw/rtl/utdb_seq.sv
hw/rtl/utdb_dp.sv
hw/rtl/usb_transfer_descriptor_builder_unit.sv
verif/usb_transfer_descriptor_builder_unit_tb.sv
